>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the shape pair proximity test top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define SPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define SPT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define SPT_ASSERT_IMP(lbl, ante, cons)
`define SPT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

>>> design/spt_pkg.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test package
// Widths, codes and types shared by the stages of the proximity pipeline.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int MAG_BITS   = COORD_BITS;
	localparam int RAD_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * MAG_BITS;
	localparam int RSQ_BITS   = 2 * RAD_BITS;
	localparam int SUM_BITS   = RSQ_BITS;
	localparam int DIST_BITS  = 33;
	localparam int WIDE_BITS  = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;
	localparam int TERM_COUNT = 4;
	localparam int DIFF_COUNT = 2 * TERM_COUNT;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	localparam logic [1:0] REQ_DIST     = 2'd0;
	localparam logic [1:0] REQ_CONTAINS = 2'd1;
	localparam logic [1:0] REQ_MEETS    = 2'd2;

	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_CIRCLE = 2'd1;
	localparam logic [1:0] KIND_RECT   = 2'd2;

	typedef enum logic [2:0] {
		OP_BAD,
		OP_DIST,
		OP_DIST_SUB,
		OP_WITHIN,
		OP_WITHIN_SMALLER,
		OP_CORNERS,
		OP_BELOW,
		OP_FLAG
	} op_t;

	typedef struct packed {
		op_t  op;
		logic flag;
	} ctl_t;

	typedef logic signed [DIFF_BITS-1:0] diff_t;
	typedef logic [MAG_BITS-1:0]         mag_t;
	typedef logic [RAD_BITS-1:0]         rad_t;
	typedef logic [SQ_BITS-1:0]          sq_t;
	typedef logic [RSQ_BITS-1:0]         rsq_t;

endpackage

>>> design/spt_prep.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test: operand preparation
// Decodes the query and shape kinds, forms the coordinate differences and the
// radius term, and evaluates the rectangle bound comparisons.
// ----------------------------------------------------------------------------
module spt_prep import spt_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic [1:0]                   req_type,
	input  logic [1:0]                   kind_a,
	input  logic signed [COORD_BITS-1:0] a_first,
	input  logic signed [COORD_BITS-1:0] a_second,
	input  logic signed [COORD_BITS-1:0] a_third,
	input  logic signed [COORD_BITS-1:0] a_fourth,
	input  logic [1:0]                   kind_b,
	input  logic signed [COORD_BITS-1:0] b_first,
	input  logic signed [COORD_BITS-1:0] b_second,
	input  logic signed [COORD_BITS-1:0] b_third,
	input  logic signed [COORD_BITS-1:0] b_fourth,
	output diff_t                        diff_s1 [DIFF_COUNT],
	output diff_t                        rad_s1,
	output ctl_t                         ctl_s1
);

	function automatic diff_t ext(input logic signed [COORD_BITS-1:0] x);
		return $signed({x[COORD_BITS-1], x});
	endfunction

	function automatic diff_t sub(input logic signed [COORD_BITS-1:0] x,
	                              input logic signed [COORD_BITS-1:0] y);
		return ext(x) - ext(y);
	endfunction

	logic                         p_is_a;
	logic [1:0]                   pk, qk;
	logic signed [COORD_BITS-1:0] p1, p2, p3, p4, q1, q2, q3, q4;
	diff_t                        x0, x1, y0, y1;
	logic                         inside_c, overlap_c;
	diff_t                        diff_c [DIFF_COUNT];
	diff_t                        rad_c;
	ctl_t                         ctl_c;

	always_comb begin
		p_is_a = (kind_a <= kind_b);
		pk = p_is_a ? kind_a : kind_b;
		qk = p_is_a ? kind_b : kind_a;
		p1 = p_is_a ? a_first  : b_first;
		p2 = p_is_a ? a_second : b_second;
		p3 = p_is_a ? a_third  : b_third;
		p4 = p_is_a ? a_fourth : b_fourth;
		q1 = p_is_a ? b_first  : a_first;
		q2 = p_is_a ? b_second : a_second;
		q3 = p_is_a ? b_third  : a_third;
		q4 = p_is_a ? b_fourth : a_fourth;
	end

	always_comb begin
		unique case (kind_b)
			KIND_POINT: begin
				x0 = ext(b_first);
				x1 = ext(b_first);
				y0 = ext(b_second);
				y1 = ext(b_second);
			end
			KIND_CIRCLE: begin
				x0 = sub(b_first, b_third);
				x1 = ext(b_first) + ext(b_third);
				y0 = sub(b_second, b_third);
				y1 = ext(b_second) + ext(b_third);
			end
			KIND_RECT: begin
				x0 = ext(b_first);
				x1 = ext(b_third);
				y0 = ext(b_second);
				y1 = ext(b_fourth);
			end
			default: begin
				x0 = '0;
				x1 = '0;
				y0 = '0;
				y1 = '0;
			end
		endcase
		inside_c = (ext(a_first) <= x0) && (x1 <= ext(a_third))
		        && (ext(a_second) <= y0) && (y1 <= ext(a_fourth));
		overlap_c = (a_first < b_third) && (b_first < a_third)
		         && (a_second < b_fourth) && (b_second < a_fourth);
	end

	always_comb begin
		for (int i = 0; i < DIFF_COUNT; i++) begin
			diff_c[i] = '0;
		end
		rad_c = '0;
		ctl_c.op = OP_BAD;
		ctl_c.flag = 1'b0;
		unique case (req_type)
			REQ_DIST: begin
				unique case ({pk, qk})
					{KIND_POINT, KIND_POINT}: begin
						diff_c[0] = sub(p1, q1);
						diff_c[1] = sub(q1, p1);
						diff_c[4] = sub(p2, q2);
						diff_c[5] = sub(q2, p2);
						ctl_c.op = OP_DIST;
					end
					{KIND_POINT, KIND_CIRCLE}: begin
						diff_c[0] = sub(p1, q1);
						diff_c[1] = sub(q1, p1);
						diff_c[4] = sub(p2, q2);
						diff_c[5] = sub(q2, p2);
						rad_c = ext(q3);
						ctl_c.op = OP_DIST_SUB;
					end
					{KIND_POINT, KIND_RECT}: begin
						diff_c[0] = sub(q1, p1);
						diff_c[1] = sub(p1, q3);
						diff_c[4] = sub(q2, p2);
						diff_c[5] = sub(p2, q4);
						ctl_c.op = OP_DIST;
					end
					{KIND_CIRCLE, KIND_CIRCLE}: begin
						diff_c[0] = sub(p1, q1);
						diff_c[1] = sub(q1, p1);
						diff_c[4] = sub(p2, q2);
						diff_c[5] = sub(q2, p2);
						rad_c = ext(p3) + ext(q3);
						ctl_c.op = OP_DIST_SUB;
					end
					{KIND_CIRCLE, KIND_RECT}: begin
						diff_c[0] = sub(q1, p1);
						diff_c[1] = sub(p1, q3);
						diff_c[4] = sub(q2, p2);
						diff_c[5] = sub(p2, q4);
						rad_c = ext(p3);
						ctl_c.op = OP_DIST_SUB;
					end
					{KIND_RECT, KIND_RECT}: begin
						diff_c[0] = sub(p1, q3);
						diff_c[1] = sub(q1, p3);
						diff_c[4] = sub(p2, q4);
						diff_c[5] = sub(q2, p4);
						ctl_c.op = OP_DIST;
					end
					default: begin
						ctl_c.op = OP_BAD;
					end
				endcase
			end
			REQ_CONTAINS: begin
				unique case (kind_a)
					KIND_CIRCLE: begin
						diff_c[0] = sub(a_first, b_first);
						diff_c[1] = sub(b_first, a_first);
						diff_c[4] = sub(a_second, b_second);
						diff_c[5] = sub(b_second, a_second);
						unique case (kind_b)
							KIND_POINT: begin
								rad_c = ext(a_third);
								ctl_c.op = OP_WITHIN;
							end
							KIND_CIRCLE: begin
								rad_c = sub(a_third, b_third);
								ctl_c.op = OP_WITHIN_SMALLER;
								ctl_c.flag = (b_third <= a_third);
							end
							KIND_RECT: begin
								diff_c[2] = sub(a_first, b_third);
								diff_c[3] = sub(b_third, a_first);
								diff_c[6] = sub(a_second, b_fourth);
								diff_c[7] = sub(b_fourth, a_second);
								rad_c = ext(a_third);
								ctl_c.op = OP_CORNERS;
							end
							default: begin
								ctl_c.op = OP_BAD;
							end
						endcase
					end
					KIND_RECT: begin
						ctl_c.flag = inside_c;
						ctl_c.op = (kind_b == KIND_POINT || kind_b == KIND_CIRCLE
						         || kind_b == KIND_RECT) ? OP_FLAG : OP_BAD;
					end
					default: begin
						ctl_c.op = OP_BAD;
					end
				endcase
			end
			REQ_MEETS: begin
				unique case ({kind_a, kind_b})
					{KIND_CIRCLE, KIND_CIRCLE}: begin
						diff_c[0] = sub(a_first, b_first);
						diff_c[1] = sub(b_first, a_first);
						diff_c[4] = sub(a_second, b_second);
						diff_c[5] = sub(b_second, a_second);
						rad_c = ext(a_third) + ext(b_third);
						ctl_c.op = OP_BELOW;
					end
					{KIND_CIRCLE, KIND_RECT}: begin
						diff_c[0] = sub(b_first, a_first);
						diff_c[1] = sub(a_first, b_third);
						diff_c[4] = sub(b_second, a_second);
						diff_c[5] = sub(a_second, b_fourth);
						rad_c = ext(a_third);
						ctl_c.op = OP_BELOW;
					end
					{KIND_RECT, KIND_CIRCLE}: begin
						diff_c[0] = sub(a_first, b_first);
						diff_c[1] = sub(b_first, a_third);
						diff_c[4] = sub(a_second, b_second);
						diff_c[5] = sub(b_second, a_fourth);
						rad_c = ext(b_third);
						ctl_c.op = OP_BELOW;
					end
					{KIND_RECT, KIND_RECT}: begin
						ctl_c.flag = overlap_c;
						ctl_c.op = OP_FLAG;
					end
					default: begin
						ctl_c.op = OP_BAD;
					end
				endcase
			end
			default: begin
				ctl_c.op = OP_BAD;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_c;
			rad_s1  <= rad_c;
			ctl_s1  <= ctl_c;
		end
	end

endmodule

>>> design/spt_square.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test: magnitudes and squares
// Reduces each difference pair to a clamped magnitude, then squares the four
// axis terms and the radius term in a stage of their own.
// ----------------------------------------------------------------------------
module spt_square import spt_pkg::*; (
	input  logic  clk,
	input  logic  en2,
	input  logic  en3,
	input  diff_t diff_s1 [DIFF_COUNT],
	input  diff_t rad_s1,
	input  ctl_t  ctl_s1,
	output sq_t   sq_s3 [TERM_COUNT],
	output rsq_t  rsq_s3,
	output ctl_t  ctl_s3
);

	function automatic mag_t clamp_max(input diff_t d0, input diff_t d1);
		diff_t m;
		m = (d0 > d1) ? d0 : d1;
		return (m > 0) ? m[MAG_BITS-1:0] : '0;
	endfunction

	mag_t term_s2 [TERM_COUNT];
	rad_t rad_s2;
	ctl_t ctl_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < TERM_COUNT; i++) begin
				term_s2[i] <= clamp_max(diff_s1[2*i], diff_s1[2*i+1]);
			end
			rad_s2 <= rad_s1[DIFF_BITS-1] ? rad_t'(-rad_s1) : rad_t'(rad_s1);
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int i = 0; i < TERM_COUNT; i++) begin
				sq_s3[i] <= SQ_BITS'(term_s2[i]) * SQ_BITS'(term_s2[i]);
			end
			rsq_s3 <= RSQ_BITS'(rad_s2) * RSQ_BITS'(rad_s2);
			ctl_s3 <= ctl_s2;
		end
	end

endmodule

>>> design/spt_decide.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test: result stage
// Sums the squared axis terms, compares them with the squared radius term and
// registers the result word.
// ----------------------------------------------------------------------------
module spt_decide import spt_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  sq_t                  sq_s3 [TERM_COUNT],
	input  rsq_t                 rsq_s3,
	input  ctl_t                 ctl_s3,
	output logic [DIST_BITS-1:0] dist_s4,
	output logic                 verdict_s4,
	output logic                 unsup_s4
);

	function automatic logic [DIST_BITS-1:0] clip(input logic [SUM_BITS-1:0] v);
		logic [WIDE_BITS-1:0] w;
		w = WIDE_BITS'(v);
		return (w > WIDE_BITS'(DIST_MAX)) ? DIST_MAX : w[DIST_BITS-1:0];
	endfunction

	logic [SUM_BITS-1:0]  s02, s03, s12, s13;
	logic [DIST_BITS-1:0] dist_c;
	logic                 verdict_c, unsup_c;

	always_comb begin
		s02 = SUM_BITS'(sq_s3[0]) + SUM_BITS'(sq_s3[2]);
		s03 = SUM_BITS'(sq_s3[0]) + SUM_BITS'(sq_s3[3]);
		s12 = SUM_BITS'(sq_s3[1]) + SUM_BITS'(sq_s3[2]);
		s13 = SUM_BITS'(sq_s3[1]) + SUM_BITS'(sq_s3[3]);
		dist_c = '0;
		verdict_c = 1'b0;
		unsup_c = 1'b0;
		unique case (ctl_s3.op)
			OP_BAD: begin
				unsup_c = 1'b1;
			end
			OP_DIST: begin
				dist_c = clip(s02);
			end
			OP_DIST_SUB: begin
				dist_c = clip((s02 > rsq_s3) ? s02 - rsq_s3 : '0);
			end
			OP_WITHIN: begin
				verdict_c = (s02 <= rsq_s3);
			end
			OP_WITHIN_SMALLER: begin
				verdict_c = ctl_s3.flag && (s02 <= rsq_s3);
			end
			OP_CORNERS: begin
				verdict_c = (s02 <= rsq_s3) && (s03 <= rsq_s3)
				         && (s12 <= rsq_s3) && (s13 <= rsq_s3);
			end
			OP_BELOW: begin
				verdict_c = (s02 < rsq_s3);
			end
			OP_FLAG: begin
				verdict_c = ctl_s3.flag;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s4    <= dist_c;
			verdict_s4 <= verdict_c;
			unsup_s4   <= unsup_c;
		end
	end

endmodule

>>> design/shape_pair_proximity_test.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test
// Squared distance, containment and overlap queries on pairs of points,
// circles and axis-aligned rectangles, in a four-stage pipeline.
//
//   channel   handshake             fields
//   request   req_valid, req_stall  req_type, kind_a, a_*, kind_b, b_*
//   response  rsp_valid, rsp_stall  dist_sq, verdict, unsupported
//
// One request word is taken every cycle while req_stall is low; its response leaves from stage four.
// Stage work: operand select and subtract, magnitudes, squares, sums and compares.
// Each stage moves whenever its successor is empty or moving, so bubbles close up.
// A stalled response holds stage four; the request side stalls only when all
// four stages are full and the response is stalled.
// Reset clears the stage valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shape_pair_proximity_test import spt_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   req_type,
	input  logic [1:0]                   kind_a,
	input  logic signed [COORD_BITS-1:0] a_first,
	input  logic signed [COORD_BITS-1:0] a_second,
	input  logic signed [COORD_BITS-1:0] a_third,
	input  logic signed [COORD_BITS-1:0] a_fourth,
	input  logic [1:0]                   kind_b,
	input  logic signed [COORD_BITS-1:0] b_first,
	input  logic signed [COORD_BITS-1:0] b_second,
	input  logic signed [COORD_BITS-1:0] b_third,
	input  logic signed [COORD_BITS-1:0] b_fourth,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [DIST_BITS-1:0]         dist_sq,
	output logic                         verdict,
	output logic                         unsupported
);

	logic  v_s1, v_s2, v_s3, v_s4;
	logic  en1, en2, en3, en4;
	diff_t diff_s1 [DIFF_COUNT];
	diff_t rad_s1;
	ctl_t  ctl_s1;
	sq_t   sq_s3 [TERM_COUNT];
	rsq_t  rsq_s3;
	ctl_t  ctl_s3;

	assign en4 = !v_s4 || !rsp_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign req_stall = !en1;
	assign rsp_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= req_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	spt_prep u_prep (
		.clk      (clk),
		.en       (en1),
		.req_type (req_type),
		.kind_a   (kind_a),
		.a_first  (a_first),
		.a_second (a_second),
		.a_third  (a_third),
		.a_fourth (a_fourth),
		.kind_b   (kind_b),
		.b_first  (b_first),
		.b_second (b_second),
		.b_third  (b_third),
		.b_fourth (b_fourth),
		.diff_s1  (diff_s1),
		.rad_s1   (rad_s1),
		.ctl_s1   (ctl_s1)
	);

	spt_square u_square (
		.clk     (clk),
		.en2     (en2),
		.en3     (en3),
		.diff_s1 (diff_s1),
		.rad_s1  (rad_s1),
		.ctl_s1  (ctl_s1),
		.sq_s3   (sq_s3),
		.rsq_s3  (rsq_s3),
		.ctl_s3  (ctl_s3)
	);

	spt_decide u_decide (
		.clk        (clk),
		.en         (en4),
		.sq_s3      (sq_s3),
		.rsq_s3     (rsq_s3),
		.ctl_s3     (ctl_s3),
		.dist_s4    (dist_sq),
		.verdict_s4 (verdict),
		.unsup_s4   (unsupported)
	);

	`SPT_ASSERT_IMP(a_unsup_clean, rsp_valid && unsupported, dist_sq == '0 && !verdict)
	`SPT_ASSERT_IMP(a_one_answer, rsp_valid && verdict, dist_sq == '0)
	`SPT_ASSERT_IMP(a_stall_full, req_stall, v_s1 && v_s2 && v_s3 && v_s4 && rsp_stall)
	`SPT_ASSERT_NXT(a_advance, v_s3 && en4, v_s4)

endmodule

>>> tb/sv/shape_pair_proximity_test_tb.sv
// ----------------------------------------------------------------------------
// Shape pair proximity test bench
// Offers request words to the proximity pipeline and checks every response
// word against an in-bench calculation of distance, containment and overlap,
// or against the answer written in the table for typed rows. A short table of
// hand-picked requests is followed by several hundred random ones. Both sides
// idle at random, the response side holds off once for long enough to fill the
// pipeline, and the request side waits for the pipeline to empty at three points.
// ----------------------------------------------------------------------------
module shape_pair_proximity_test_tb import spt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] REQ_RESERVED  = 2'd3;
	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam int         CYCLE_LIMIT   = 200000;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [1:0] kind;
		coord_t     first;
		coord_t     second;
		coord_t     third;
		coord_t     fourth;
	} shape_t;

	typedef struct packed {
		logic [1:0] query;
		shape_t     a;
		shape_t     b;
	} query_word_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] dist_sq;
		logic                 verdict;
		logic                 unsupported;
	} answer_t;

	typedef struct packed {
		query_word_t word;
		logic        typed;
		answer_t     want;
	} vector_t;

	localparam answer_t REFUSED = '{33'd0, 1'b0, 1'b1};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic [1:0]           req_type = REQ_DIST;
	logic [1:0]           kind_a = KIND_POINT;
	coord_t               a_first = '0;
	coord_t               a_second = '0;
	coord_t               a_third = '0;
	coord_t               a_fourth = '0;
	logic [1:0]           kind_b = KIND_POINT;
	coord_t               b_first = '0;
	coord_t               b_second = '0;
	coord_t               b_third = '0;
	coord_t               b_fourth = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic [DIST_BITS-1:0] dist_sq;
	logic                 verdict;
	logic                 unsupported;

	logic [1:0] shape_kinds [3] = '{KIND_POINT, KIND_CIRCLE, KIND_RECT};
	logic [1:0] query_kinds [3] = '{REQ_DIST, REQ_CONTAINS, REQ_MEETS};

	answer_t answers_due [$];
	vector_t directed_rows [$];
	logic    offer_typed = 1'b0;
	answer_t offer_want = '0;
	bit      tx_steady = 1'b0;
	bit      rx_steady = 1'b0;
	int      rx_hold = 0;
	int      mismatches = 0;
	int      cycles = 0;

	shape_pair_proximity_test dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.kind_a      (kind_a),
		.a_first     (a_first),
		.a_second    (a_second),
		.a_third     (a_third),
		.a_fourth    (a_fourth),
		.kind_b      (kind_b),
		.b_first     (b_first),
		.b_second    (b_second),
		.b_third     (b_third),
		.b_fourth    (b_fourth),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.dist_sq     (dist_sq),
		.verdict     (verdict),
		.unsupported (unsupported)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint sq(longint v);
		return v * v;
	endfunction

	function automatic longint beyond(longint lo_gap, longint hi_gap);
		longint m;
		m = (lo_gap > hi_gap) ? lo_gap : hi_gap;
		return (m > 0) ? m : 0;
	endfunction

	function automatic longint clamp_sub(longint d, longint s);
		return (d > s) ? d - s : 0;
	endfunction

	function automatic longint centre_gap(longint x1, longint y1, longint x2, longint y2);
		return sq(x1 - x2) + sq(y1 - y2);
	endfunction

	function automatic longint box_gap(shape_t r, longint x, longint y);
		return sq(beyond(r.first - x, x - r.third)) + sq(beyond(r.second - y, y - r.fourth));
	endfunction

	function automatic bit ring_holds(shape_t c, longint x, longint y);
		return centre_gap(c.first, c.second, x, y) <= sq(c.third);
	endfunction

	function automatic bit box_holds(shape_t o, longint x0, longint y0, longint x1, longint y1);
		return o.first <= x0 && x1 <= o.third && o.second <= y0 && y1 <= o.fourth;
	endfunction

	// The first shape never has a higher kind code than the second.
	function automatic longint pair_gap(shape_t p, shape_t q);
		if (p.kind == KIND_POINT && q.kind == KIND_POINT)
			return centre_gap(p.first, p.second, q.first, q.second);
		if (p.kind == KIND_POINT && q.kind == KIND_CIRCLE)
			return clamp_sub(centre_gap(q.first, q.second, p.first, p.second), sq(q.third));
		if (p.kind == KIND_POINT)
			return box_gap(q, p.first, p.second);
		if (q.kind == KIND_CIRCLE)
			return clamp_sub(centre_gap(p.first, p.second, q.first, q.second),
				sq(longint'(p.third) + q.third));
		if (p.kind == KIND_CIRCLE)
			return clamp_sub(box_gap(q, p.first, p.second), sq(p.third));
		return sq(beyond(longint'(p.first) - q.third, longint'(q.first) - p.third))
			+ sq(beyond(longint'(p.second) - q.fourth, longint'(q.second) - p.fourth));
	endfunction

	function automatic answer_t predict(query_word_t w);
		answer_t r;
		longint  d;
		shape_t  o;
		shape_t  i;
		r = '0;
		o = w.a;
		i = w.b;
		if (w.query == REQ_RESERVED || o.kind == KIND_RESERVED || i.kind == KIND_RESERVED) begin
			r.unsupported = 1'b1;
		end else if (w.query == REQ_DIST) begin
			d = (o.kind <= i.kind) ? pair_gap(o, i) : pair_gap(i, o);
			r.dist_sq = (d > DIST_MAX) ? DIST_MAX : d[DIST_BITS-1:0];
		end else if (w.query == REQ_CONTAINS) begin
			if (o.kind == KIND_CIRCLE) begin
				if (i.kind == KIND_POINT)
					r.verdict = ring_holds(o, i.first, i.second);
				else if (i.kind == KIND_CIRCLE)
					r.verdict = i.third <= o.third
						&& centre_gap(o.first, o.second, i.first, i.second)
						<= sq(longint'(o.third) - i.third);
				else
					r.verdict = ring_holds(o, i.first, i.second)
						&& ring_holds(o, i.third, i.fourth)
						&& ring_holds(o, i.first, i.fourth)
						&& ring_holds(o, i.third, i.second);
			end else if (o.kind == KIND_RECT) begin
				if (i.kind == KIND_POINT)
					r.verdict = box_holds(o, i.first, i.second, i.first, i.second);
				else if (i.kind == KIND_CIRCLE)
					r.verdict = box_holds(o, longint'(i.first) - i.third,
						longint'(i.second) - i.third, longint'(i.first) + i.third,
						longint'(i.second) + i.third);
				else
					r.verdict = box_holds(o, i.first, i.second, i.third, i.fourth);
			end else begin
				r.unsupported = 1'b1;
			end
		end else begin
			if (o.kind == KIND_POINT || i.kind == KIND_POINT)
				r.unsupported = 1'b1;
			else if (o.kind == KIND_CIRCLE && i.kind == KIND_CIRCLE)
				r.verdict = centre_gap(o.first, o.second, i.first, i.second)
					< sq(longint'(o.third) + i.third);
			else if (o.kind == KIND_CIRCLE)
				r.verdict = box_gap(i, o.first, o.second) < sq(o.third);
			else if (i.kind == KIND_CIRCLE)
				r.verdict = box_gap(o, i.first, i.second) < sq(i.third);
			else
				r.verdict = o.first < i.third && i.first < o.third
					&& o.second < i.fourth && i.second < o.fourth;
		end
		return r;
	endfunction

	function automatic shape_t shp(logic [1:0] kind, coord_t f1, coord_t f2, coord_t f3,
			coord_t f4);
		return '{kind, f1, f2, f3, f4};
	endfunction

	function automatic query_word_t ask(logic [1:0] query, shape_t a, shape_t b);
		return '{query, a, b};
	endfunction

	function automatic coord_t near();
		return coord_t'(int'($urandom_range(0, 400)) - 200);
	endfunction

	function automatic shape_t random_shape();
		shape_t s;
		int     span_x;
		int     span_y;
		s.kind = ($urandom_range(0, 39) == 0) ? KIND_RESERVED : shape_kinds[$urandom_range(0, 2)];
		s.first = coord_t'($urandom);
		s.second = coord_t'($urandom);
		s.third = coord_t'($urandom);
		s.fourth = coord_t'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			s.first = near();
			s.second = near();
			if (s.kind == KIND_CIRCLE) begin
				s.third = ($urandom_range(0, 9) == 0) ? near() : coord_t'($urandom_range(0, 150));
			end else begin
				span_x = $urandom_range(0, 150);
				span_y = $urandom_range(0, 150);
				if ($urandom_range(0, 9) == 0)
					span_x = -span_x;
				if ($urandom_range(0, 9) == 0)
					span_y = -span_y;
				s.third = s.first + coord_t'(span_x);
				s.fourth = s.second + coord_t'(span_y);
			end
		end
		return s;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic entry(logic [1:0] query, shape_t a, shape_t b, logic typed = 1'b0,
			answer_t want = '0);
		directed_rows.push_back('{ask(query, a, b), typed, want});
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		mismatches++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	task automatic offer(query_word_t w, logic typed = 1'b0, answer_t want = '0);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid = 1'b1;
		req_type = w.query;
		kind_a = w.a.kind;
		a_first = w.a.first;
		a_second = w.a.second;
		a_third = w.a.third;
		a_fourth = w.a.fourth;
		kind_b = w.b.kind;
		b_first = w.b.first;
		b_second = w.b.second;
		b_third = w.b.third;
		b_fourth = w.b.fourth;
		offer_typed = typed;
		offer_want = want;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic await_drained();
		@(negedge clk);
		req_valid = 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rsp_stall = 1'b1;
				rx_hold--;
			end else if (left > 0) begin
				rsp_stall = 1'b1;
				left--;
			end else begin
				rsp_stall = 1'b0;
				if (!rx_steady)
					left = idle_len();
			end
		end
	end

	always @(posedge clk) begin : watch
		query_word_t seen;
		answer_t     got;
		answer_t     want;
		if (arst_n && req_valid && !req_stall) begin
			seen = '{req_type, '{kind_a, a_first, a_second, a_third, a_fourth},
				'{kind_b, b_first, b_second, b_third, b_fourth}};
			answers_due.push_back(offer_typed ? offer_want : predict(seen));
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{dist_sq, verdict, unsupported};
			if (answers_due.size() == 0) begin
				report_mismatch("response word with none outstanding, dist_sq", got.dist_sq, 0);
			end else begin
				want = answers_due.pop_front();
				if (got.dist_sq != want.dist_sq)
					report_mismatch("dist_sq", got.dist_sq, want.dist_sq);
				if (got.verdict != want.verdict)
					report_mismatch("verdict", got.verdict, want.verdict);
				if (got.unsupported != want.unsupported)
					report_mismatch("unsupported", got.unsupported, want.unsupported);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		entry(REQ_DIST, shp(KIND_POINT, -32768, -32768, 0, 0),
			shp(KIND_POINT, 32767, 32767, 0, 0), 1'b1, '{33'd8589672450, 1'b0, 1'b0});
		entry(REQ_DIST, shp(KIND_POINT, 5, 5, -1, -1), shp(KIND_POINT, 5, 5, 7, 7),
			1'b1, '{33'd0, 1'b0, 1'b0});
		entry(REQ_DIST, shp(KIND_CIRCLE, 0, 0, 10, 0), shp(KIND_POINT, 3, 4, 0, 0),
			1'b1, '{33'd0, 1'b0, 1'b0});
		entry(REQ_DIST, shp(KIND_CIRCLE, -32768, 0, -32768, 0),
			shp(KIND_CIRCLE, 32767, 0, -32768, 0));
		entry(REQ_DIST, shp(KIND_RECT, -10, -10, 10, 10), shp(KIND_POINT, 20, 0, 0, 0),
			1'b1, '{33'd100, 1'b0, 1'b0});
		entry(REQ_DIST, shp(KIND_RECT, 10, 10, -10, -10),
			shp(KIND_RECT, -32768, -32768, 32767, 32767));
		entry(REQ_DIST, shp(KIND_CIRCLE, 0, 0, 5, 0), shp(KIND_RECT, 20, 30, 40, 50));
		entry(REQ_DIST, shp(KIND_RECT, 32767, 32767, 32767, 32767),
			shp(KIND_RECT, -32768, -32768, -32768, -32768), 1'b1,
			'{33'd8589672450, 1'b0, 1'b0});
		entry(REQ_CONTAINS, shp(KIND_POINT, 0, 0, 0, 0), shp(KIND_POINT, 0, 0, 0, 0),
			1'b1, REFUSED);
		entry(REQ_CONTAINS, shp(KIND_CIRCLE, 0, 0, 5, 0), shp(KIND_POINT, 3, 4, 0, 0),
			1'b1, '{33'd0, 1'b1, 1'b0});
		entry(REQ_CONTAINS, shp(KIND_CIRCLE, 0, 0, 10, 0), shp(KIND_CIRCLE, 1, 1, 2, 0));
		entry(REQ_CONTAINS, shp(KIND_CIRCLE, 0, 0, 10, 0), shp(KIND_CIRCLE, 0, 0, 20, 0));
		entry(REQ_CONTAINS, shp(KIND_CIRCLE, 0, 0, 100, 0), shp(KIND_RECT, -50, -50, 50, 50));
		entry(REQ_CONTAINS, shp(KIND_RECT, -10, -10, 10, 10), shp(KIND_POINT, 10, -10, 0, 0),
			1'b1, '{33'd0, 1'b1, 1'b0});
		entry(REQ_CONTAINS, shp(KIND_RECT, -10, -10, 10, 10), shp(KIND_CIRCLE, 0, 0, 10, 0));
		entry(REQ_CONTAINS, shp(KIND_RECT, -32768, -32768, 32767, 32767),
			shp(KIND_RECT, -32768, -32768, 32767, 32767), 1'b1, '{33'd0, 1'b1, 1'b0});
		entry(REQ_CONTAINS, shp(KIND_RECT, 5, 5, -5, -5), shp(KIND_RECT, 0, 0, 0, 0));
		entry(REQ_MEETS, shp(KIND_POINT, 0, 0, 0, 0), shp(KIND_CIRCLE, 0, 0, 5, 0),
			1'b1, REFUSED);
		entry(REQ_MEETS, shp(KIND_RECT, 0, 0, 9, 9), shp(KIND_POINT, 1, 1, 0, 0),
			1'b1, REFUSED);
		entry(REQ_MEETS, shp(KIND_CIRCLE, 0, 0, 3, 0), shp(KIND_CIRCLE, 6, 0, 3, 0));
		entry(REQ_MEETS, shp(KIND_CIRCLE, 0, 0, 5, 0), shp(KIND_RECT, 3, -1, 10, 1));
		entry(REQ_MEETS, shp(KIND_RECT, 0, 0, 10, 10), shp(KIND_CIRCLE, 12, 5, -3, 0));
		entry(REQ_MEETS, shp(KIND_RECT, 0, 0, 10, 10), shp(KIND_RECT, 10, 0, 20, 10));
		entry(REQ_RESERVED, shp(KIND_RECT, 0, 0, 10, 10), shp(KIND_RECT, 1, 1, 2, 2),
			1'b1, REFUSED);
		entry(REQ_DIST, shp(KIND_RESERVED, 1, 2, 3, 4), shp(KIND_POINT, 0, 0, 0, 0),
			1'b1, REFUSED);
		entry(REQ_MEETS, shp(KIND_CIRCLE, 0, 0, 9, 0), shp(KIND_RESERVED, 0, 0, 9, 9),
			1'b1, REFUSED);
		foreach (directed_rows[n])
			offer(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);

		// Response side holds off while words keep coming, so the pipeline backs up.
		tx_steady = 1'b1;
		rx_hold = 80;
		repeat (24)
			offer(ask(query_kinds[$urandom_range(0, 2)], random_shape(), random_shape()));
		tx_steady = 1'b0;
		await_drained();

		for (int n = 0; n < 600; n++) begin
			if (n % 75 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			if (n == 300)
				await_drained();
			offer(ask(($urandom_range(0, 39) == 0) ? REQ_RESERVED
				: query_kinds[$urandom_range(0, 2)], random_shape(), random_shape()));
		end
		await_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/spt_pkg.sv
design/spt_prep.sv
design/spt_square.sv
design/spt_decide.sv
design/shape_pair_proximity_test.sv
tb/sv/shape_pair_proximity_test_tb.sv
